FILE: rtl/core/fixed_block_free_list_allocator_core_macros.svh
// Assertion helpers shared by the allocator core.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Check on every rising clock edge outside reset.
`define FBFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define FBFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fbfa_pkg.sv
package fbfa_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS   = 256;
  localparam int WORD_BYTES   = 8;
  localparam int HEADER_BYTES = 8;

  // Field widths
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int COUNT_W    = 9;
  localparam int BYTES_W    = 13;
  localparam int RBYTES_W   = BYTES_W + 1;
  localparam int OFFSET_W   = 20;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

  // Counts and sentinels
  localparam logic [LINK_W-1:0]  STACK_EMPTY  = LINK_W'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] POOL_LIMIT   = COUNT_W'(NUM_BLOCKS < 256 ? NUM_BLOCKS : 256);
  localparam logic [BYTES_W-1:0] BYTES_RESET  = BYTES_W'(8);

  // Link memory access, one read and one write port
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
  } link_req_t;

  // Round a block size up to a whole number of words
  function automatic logic [RBYTES_W-1:0] round_bytes(input logic [BYTES_W-1:0] b);
    logic [RBYTES_W-1:0] s;
    s = {1'b0, b} + RBYTES_W'(WORD_BYTES - 1);
    return RBYTES_W'((s / WORD_BYTES) * WORD_BYTES);
  endfunction

endpackage

FILE: rtl/core/fbfa_if.sv
// Request channel: operation code and block index
interface fbfa_in_if;
  import fbfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  block_index;
  modport source (output valid, func, block_index, input ready);
  modport sink (input valid, func, block_index, output ready);
endinterface

// Response channel: one word per operation
interface fbfa_out_if;
  import fbfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COUNT_W-1:0]  free_count;
  modport source (output valid, status, granted_index, byte_offset, free_count, input ready);
  modport sink (input valid, status, granted_index, byte_offset, free_count, output ready);
endinterface

FILE: rtl/core/fixed_block_free_list_allocator_core.sv
// Channel | Dir | Word
// --------+-----+---------------------------------------------------
// req     | in  | func, block_index
// rsp     | out | status, granted_index, byte_offset, free_count
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Each operation is accepted with a link read, then executed and written back.
// The link memory's registered read sets that split.
// A new request is accepted while the previous response waits in the output register.
// Execute stalls only while the output register is full and not taken.
// Synchronous reset empties the stack and restores the full pool; no clearing pass.
module fixed_block_free_list_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  fbfa_in_if.sink                         req,
  fbfa_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [fbfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfa_pkg::*;
  `include "fixed_block_free_list_allocator_core_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                state;
  logic [FUNC_W-1:0]   op_func;
  logic [IDX_W-1:0]    op_index;
  logic [COUNT_W-1:0]  pool_count;
  logic [RBYTES_W-1:0] blk_bytes;
  logic [LINK_W-1:0]   stack_top;
  logic [COUNT_W-1:0]  untouched_mark;
  logic [COUNT_W-1:0]  free_total;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [IDX_W-1:0]    rsp_index;
  logic [OFFSET_W-1:0] rsp_offset;
  logic [COUNT_W-1:0]  rsp_count;

  logic [LINK_W-1:0]   link_rd;
  link_req_t           link_req;

  logic                      accept;
  logic                      finish;
  logic                      top_live;
  logic                      mark_live;
  logic                      free_ok;
  logic [IDX_W-1:0]          got;
  logic [IDX_W+RBYTES_W-1:0] prod;
  logic [LINK_W-1:0]         stack_top_next;
  logic [COUNT_W-1:0]        untouched_mark_next;
  logic [COUNT_W-1:0]        free_total_next;
  logic [STATUS_W-1:0]       status_next;
  logic [IDX_W-1:0]          granted_next;
  logic [OFFSET_W-1:0]       offset_next;

  // Handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign finish    = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  // Link memory: read at the top on accept, push on execute
  assign link_req.rd_en   = accept;
  assign link_req.rd_addr = stack_top[IDX_W-1:0];
  assign link_req.wr_en   = finish && (op_func == FUNC_FREE) && free_ok;
  assign link_req.wr_addr = op_index;
  assign link_req.wr_data = stack_top;

  fbfa_link_ram u_link_ram (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rd)
  );

  // Execute one operation against the current state
  assign top_live  = (stack_top < STACK_EMPTY);
  assign mark_live = (untouched_mark < pool_count);
  assign free_ok   = ({1'b0, op_index} < pool_count);
  assign got       = top_live ? stack_top[IDX_W-1:0] : untouched_mark[IDX_W-1:0];
  assign prod      = {{RBYTES_W{1'b0}}, got} * {{IDX_W{1'b0}}, blk_bytes};

  always_comb begin
    stack_top_next      = stack_top;
    untouched_mark_next = untouched_mark;
    free_total_next     = free_total;
    status_next         = ST_OK;
    granted_next        = '0;
    offset_next         = '0;
    case (op_func)
      FUNC_ALLOC: begin
        if (top_live || mark_live) begin
          if (top_live) begin
            stack_top_next = link_rd;
          end else begin
            untouched_mark_next = untouched_mark + COUNT_W'(1);
          end
          granted_next = got;
          offset_next  = OFFSET_W'(prod) + OFFSET_W'(HEADER_BYTES);
          if (free_total != '0) begin
            free_total_next = free_total - COUNT_W'(1);
          end
        end else begin
          status_next = ST_EMPTY;
        end
      end
      FUNC_FREE: begin
        if (free_ok) begin
          stack_top_next = {1'b0, op_index};
          if (free_total != COUNT_MAX) begin
            free_total_next = free_total + COUNT_W'(1);
          end
        end else begin
          status_next = ST_RANGE;
        end
      end
      FUNC_INIT: begin
        stack_top_next      = STACK_EMPTY;
        untouched_mark_next = '0;
        free_total_next     = pool_count;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stack_top      <= STACK_EMPTY;
      untouched_mark <= '0;
      free_total     <= POOL_LIMIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            state          <= S_IDLE;
            stack_top      <= stack_top_next;
            untouched_mark <= untouched_mark_next;
            free_total     <= free_total_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the request word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= req.func;
      op_index <= req.block_index;
    end
  end

  // Configuration registers, kept in the form the datapath uses
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= POOL_LIMIT;
      blk_bytes  <= round_bytes(BYTES_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: begin
          pool_count <= (cfg_data[COUNT_W-1:0] > POOL_LIMIT) ? POOL_LIMIT
                                                              : cfg_data[COUNT_W-1:0];
        end
        REG_BLOCK_BYTES: blk_bytes <= round_bytes(cfg_data[BYTES_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_status <= status_next;
      rsp_index  <= granted_next;
      rsp_offset <= offset_next;
      rsp_count  <= free_total_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.granted_index = rsp_index;
  assign rsp.byte_offset   = rsp_offset;
  assign rsp.free_count    = rsp_count;

  // Checks
  `FBFA_ASSERT(a_accept_exec, accept |=> state == S_EXEC, "accept did not start execute")
  `FBFA_ASSERT(a_pop_link, finish && op_func == FUNC_ALLOC && top_live |=> stack_top == $past(link_rd), "pop did not follow the link")
  `FBFA_ASSERT(a_push_top, finish && op_func == FUNC_FREE && free_ok |=> stack_top == LINK_W'($past(op_index)), "push did not set the top")
  `FBFA_ASSERT(a_rsp_source, $rose(rsp.valid) |-> $past(state == S_EXEC), "response without execute")
  `FBFA_ASSERT_ALWAYS(a_reset_clear, rst |=> !rsp.valid && state == S_IDLE, "reset left work pending")

endmodule

FILE: rtl/core/fbfa_link_ram.sv
module fbfa_link_ram (
  input  logic                        clk,
  input  fbfa_pkg::link_req_t         req,
  output logic [fbfa_pkg::LINK_W-1:0] rd_data
);
  import fbfa_pkg::*;

  logic [LINK_W-1:0] mem [NUM_BLOCKS];

  // Write the pushed link
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read the link under the stack top, registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: bench/tb_fixed_block_free_list_allocator_core.sv
`timescale 1ns / 1ps
module tb_fixed_block_free_list_allocator_core;
  import fbfa_pkg::*;

  // Spare operation code: the block treats it as a no-op
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
  } rsp_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fbfa_in_if  req_ch ();
  fbfa_out_if rsp_ch ();

  fixed_block_free_list_allocator_core uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the allocator state and its registers
  logic [LINK_W-1:0]  link_mem [NUM_BLOCKS];
  logic [LINK_W-1:0]  stack_head;
  logic [COUNT_W-1:0] next_fresh;
  logic [COUNT_W-1:0] free_blocks;
  logic [COUNT_W-1:0] cfg_count = COUNT_W'(256);
  logic [BYTES_W-1:0] cfg_bytes = BYTES_W'(8);

  rsp_word_t due_words[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        stall_tick = 0;
  int        burst_left = 0;
  int        pool_n = 256;
  bit        idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_blocks();
    return (int'(cfg_count) < NUM_BLOCKS) ? int'(cfg_count) : NUM_BLOCKS;
  endfunction

  function automatic int block_stride();
    return ((int'(cfg_bytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
  endfunction

  function automatic void clear_pool();
    stack_head  = STACK_EMPTY;
    next_fresh  = '0;
    free_blocks = COUNT_W'(eff_blocks());
  endfunction

  // Apply one operation to the shadow pool and return the word it produces
  function automatic rsp_word_t alloc_step(input logic [FUNC_W-1:0] func,
                                           input logic [IDX_W-1:0] idx);
    rsp_word_t r;
    int        n;
    int        got;
    bit        ok;
    r   = '0;
    n   = eff_blocks();
    got = 0;
    ok  = 1'b0;
    case (func)
      FUNC_ALLOC: begin
        // pop the freed stack first, then take the lowest untouched block
        if (stack_head < STACK_EMPTY) begin
          got        = int'(stack_head);
          stack_head = link_mem[stack_head[IDX_W-1:0]];
          ok         = 1'b1;
        end else if (int'(next_fresh) < n) begin
          got        = int'(next_fresh);
          next_fresh = next_fresh + COUNT_W'(1);
          ok         = 1'b1;
        end
        if (ok) begin
          r.granted_index = IDX_W'(got);
          r.byte_offset   = OFFSET_W'(HEADER_BYTES + got * block_stride());
          if (free_blocks != '0) free_blocks = free_blocks - COUNT_W'(1);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      FUNC_FREE: begin
        if (int'(idx) >= n) begin
          r.status = ST_RANGE;
        end else begin
          link_mem[idx] = stack_head;
          stack_head    = LINK_W'(idx);
          if (free_blocks != COUNT_MAX) free_blocks = free_blocks + COUNT_W'(1);
        end
      end
      FUNC_INIT: clear_pool();
      default: ;
    endcase
    r.free_count = free_blocks;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
    errors++;
  endtask

  // Track register writes, predict on each accepted request, check each response
  always @(posedge clk) begin : check_words
    rsp_word_t want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_COUNT) cfg_count = cfg_data[COUNT_W-1:0];
        else if (cfg_index == REG_BLOCK_BYTES) cfg_bytes = cfg_data[BYTES_W-1:0];
      end
      if (req_ch.valid && req_ch.ready)
        due_words.push_back(alloc_step(req_ch.func, req_ch.block_index));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = due_words.pop_front();
          if (rsp_ch.status !== want.status)
            report_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.granted_index !== want.granted_index)
            report_mismatch("granted_index", rsp_ch.granted_index, want.granted_index);
          if (rsp_ch.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", rsp_ch.byte_offset, want.byte_offset);
          if (rsp_ch.free_count !== want.free_count)
            report_mismatch("free_count", rsp_ch.free_count, want.free_count);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Response stalls: rotate through open, sparse, long and coin-flip stretches; always open while idle_on is clear
  always @(posedge clk) begin : rsp_stalls
    stall_tick++;
    if (!idle_on) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      case ((stall_tick / 64) % 4)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_ch.ready <= ((stall_tick % 16) >= 12);
        default: rsp_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Send one request word; the sender runs in bursts with random gaps, none while idle_on is clear
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (!idle_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.func        <= func;
    req_ch.block_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Hold the sender until every expected word has come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Write both registers; only called while the block is idle
  task automatic set_pool(input int count, input int bytes);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= REG_BLOCK_BYTES;
    cfg_data  <= CFG_DATA_W'(bytes);
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_n = (count < NUM_BLOCKS) ? count : NUM_BLOCKS;
  endtask

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  // Allocation order, LIFO reuse, spare code and init at the reset setting
  task automatic test_directed_basics();
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_FREE, IDX_W'(1));
    send_op(FUNC_FREE, IDX_W'(0));
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_FREE, IDX_W'(255));
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_NOP, any_index());
    send_op(FUNC_INIT, any_index());
    send_op(FUNC_ALLOC, any_index());
  endtask

  // One-block pool with zero size, empty pool, range errors, double free, offset wrap
  task automatic test_directed_edges();
    wait_idle();
    set_pool(1, 0);
    send_op(FUNC_INIT, any_index());
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_FREE, IDX_W'(1));
    send_op(FUNC_FREE, IDX_W'(255));
    send_op(FUNC_FREE, IDX_W'(0));
    send_op(FUNC_FREE, IDX_W'(0));
    send_op(FUNC_ALLOC, any_index());
    send_op(FUNC_ALLOC, any_index());
    wait_idle();
    set_pool(256, 8191);
    send_op(FUNC_INIT, any_index());
    send_op(FUNC_FREE, IDX_W'(255));
    send_op(FUNC_ALLOC, any_index());
  endtask

  // Reconfigure, optionally init, then drive a random mix of operations
  task automatic random_phase(input int count, input int bytes, input bit do_init,
                              input int n_items, input int free_pct, input bit init_ok);
    int                 r;
    logic [IDX_W-1:0]   idx;
    logic [FUNC_W-1:0]  func;
    wait_idle();
    set_pool(count, bytes);
    if (do_init) send_op(FUNC_INIT, any_index());
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (pool_n > 0 && $urandom_range(0, 9) != 0)
        idx = IDX_W'($urandom_range(0, pool_n - 1));
      else
        idx = any_index();
      if (r < free_pct)                       func = FUNC_FREE;
      else if (r < free_pct + 3)              func = FUNC_NOP;
      else if (init_ok && r < free_pct + 6)   func = FUNC_INIT;
      else                                    func = FUNC_ALLOC;
      send_op(func, idx);
      // drain now and then so the block goes fully quiet mid-phase
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
  endtask

  // Several register settings, some changed without init
  task automatic test_reconfig_phases();
    random_phase(256, 8, 1'b1, 40, 42, 1'b1);
    random_phase(4, 8191, 1'b0, 40, 30, 1'b1);
    random_phase(0, 13, 1'b0, 25, 40, 1'b1);
    idle_on = 1'b0;
    random_phase(511, 1, 1'b1, 40, 42, 1'b1);
    idle_on = 1'b1;
    repeat (2)
      random_phase($urandom_range(1, 256), $urandom_range(0, 8191), 1'($urandom_range(0, 1)),
                   30, 42, 1'b1);
  endtask

  // Push the free count up to its ceiling with repeated frees
  task automatic test_count_saturation();
    random_phase(256, 4096, 1'b1, 300, 94, 1'b0);
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_ALLOC;
    req_ch.block_index = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) link_mem[i] = '0;
    clear_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_directed_edges();
    test_reconfig_phases();
    test_count_saturation();

    // drain, then watch a little longer for stray words
    wait_idle();
    repeat (16) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
